// ----- sv/assert_macros.svh -----
// Assertion macros shared by the validator RTL.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/u8v_pkg.sv -----
// Shared types, constants and code point checks for the UTF-8 validator.
// No dependencies.
package u8v_pkg;

  localparam logic [20:0] CP_MIN_2B   = 21'h00080;
  localparam logic [20:0] CP_MIN_3B   = 21'h00800;
  localparam logic [20:0] CP_MIN_4B   = 21'h10000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h0D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h0DFFF;
  localparam logic [20:0] CP_CTRL_TOP = 21'h0001F;
  localparam logic [20:0] CP_DEL      = 21'h0007F;

  // Continuation byte counts of a sequence
  localparam logic [1:0] EXTRA_NONE  = 2'd0;
  localparam logic [1:0] EXTRA_ONE   = 2'd1;
  localparam logic [1:0] EXTRA_TWO   = 2'd2;
  localparam logic [1:0] EXTRA_THREE = 2'd3;

  typedef struct packed {
    logic [1:0]  pending;
    logic [1:0]  seq_len;
    logic [20:0] cp;
    logic        failed;
  } u8v_state_t;

  // True when a completed code point is acceptable for its encoded length.
  function automatic logic cp_ok(input logic [20:0] cp, input logic [1:0] extra);
    logic ok;
    ok = 1'b1;
    if (extra == EXTRA_ONE   && cp < CP_MIN_2B) ok = 1'b0;
    if (extra == EXTRA_TWO   && cp < CP_MIN_3B) ok = 1'b0;
    if (extra == EXTRA_THREE && cp < CP_MIN_4B) ok = 1'b0;
    if (cp > CP_MAX) ok = 1'b0;
    if (cp inside {[CP_SURR_LO:CP_SURR_HI]}) ok = 1'b0;
    if (cp <= CP_CTRL_TOP || cp == CP_DEL) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ----- sv/u8v_in_stage.sv -----
// Input register for the byte channel of the UTF-8 validator.
// Depends on nothing beyond the handshake from the top level.
module u8v_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       advance,
  output logic       beat_valid,
  output logic [7:0] beat_byte,
  output logic       beat_last
);

  // Free when empty or when the held beat moves on this cycle
  assign data_ready = !beat_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (data_ready) begin
      beat_valid <= data_valid;
    end
    if (data_ready && data_valid) begin
      beat_byte <= data_byte;
      beat_last <= last_byte;
    end
  end

endmodule

// ----- sv/u8v_step.sv -----
// Per-byte decode step: next decoder state from current state and one byte.
// Depends on u8v_pkg.
module u8v_step (
  input  u8v_pkg::u8v_state_t st,
  input  logic [7:0]          c,
  output u8v_pkg::u8v_state_t nxt
);

  logic [20:0] cp_shift;

  assign cp_shift = {st.cp[14:0], c[5:0]};

  always_comb begin
    nxt = st;
    if (!st.failed) begin
      if (st.pending == u8v_pkg::EXTRA_NONE) begin
        if (!c[7]) begin
          if (!u8v_pkg::cp_ok({13'd0, c}, u8v_pkg::EXTRA_NONE)) nxt.failed = 1'b1;
        end else if (c[7:5] == 3'b110) begin
          nxt.cp      = {16'd0, c[4:0]};
          nxt.seq_len = u8v_pkg::EXTRA_ONE;
          nxt.pending = u8v_pkg::EXTRA_ONE;
        end else if (c[7:4] == 4'b1110) begin
          nxt.cp      = {17'd0, c[3:0]};
          nxt.seq_len = u8v_pkg::EXTRA_TWO;
          nxt.pending = u8v_pkg::EXTRA_TWO;
        end else if (c[7:3] == 5'b11110) begin
          // F5..F7 pass here and fail on the range check at the end
          nxt.cp      = {18'd0, c[2:0]};
          nxt.seq_len = u8v_pkg::EXTRA_THREE;
          nxt.pending = u8v_pkg::EXTRA_THREE;
        end else begin
          nxt.failed = 1'b1;
        end
      end else if (c[7:6] != 2'b10) begin
        nxt.failed = 1'b1;
      end else if (st.pending == u8v_pkg::EXTRA_ONE) begin
        // sequence complete
        if (!u8v_pkg::cp_ok(cp_shift, st.seq_len)) nxt.failed = 1'b1;
        nxt.pending = u8v_pkg::EXTRA_NONE;
        nxt.seq_len = u8v_pkg::EXTRA_NONE;
        nxt.cp      = '0;
      end else begin
        nxt.cp      = cp_shift;
        nxt.pending = st.pending - 2'd1;
      end
    end
  end

endmodule

// ----- sv/strict_utf8_validator.sv -----
// Strict UTF-8 string validator: top level with decoder state and verdict register.
// Depends on u8v_pkg, u8v_in_stage, u8v_step and assert_macros.svh.
//
//  channel  dir  handshake                  payload
//  data     in   data_valid / data_ready    data_byte[7:0], last_byte
//  result   out  result_valid / result_ready string_valid
//
// One byte a cycle unless a last beat is held; verdicts are registered outputs.
// Throughput is set by the single decode step between input and state registers.
// Only a last beat waits on the result register; other beats never stall.
// rst clears the decoder state, the input stage and the result valid flag.
`include "assert_macros.svh"

module strict_utf8_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       string_valid
);

  logic                beat_valid;
  logic [7:0]          beat_byte;
  logic                beat_last;
  logic                advance;
  u8v_pkg::u8v_state_t state;
  u8v_pkg::u8v_state_t state_next;
  logic                verdict;

  u8v_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat_byte  (beat_byte),
    .beat_last  (beat_last)
  );

  u8v_step u_step (
    .st  (state),
    .c   (beat_byte),
    .nxt (state_next)
  );

  assign advance = beat_valid && (!beat_last || !result_valid || result_ready);
  assign verdict = !state_next.failed && (state_next.pending == u8v_pkg::EXTRA_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        // a verdict ends the string: back to reset state
        state <= beat_last ? '0 : state_next;
      end
      if (advance && beat_last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (advance && beat_last) begin
      string_valid <= verdict;
    end
  end

  `ASSERT_CLK(a_pending_le_len,
    state.pending <= state.seq_len,
    "pending count exceeds sequence length")
  `ASSERT_CLK(a_clear_after_last,
    advance && beat_last |=> state == '0,
    "state not cleared after last beat")
  `ASSERT_CLK(a_result_from_last,
    $rose(result_valid) |-> $past(advance && beat_last),
    "result raised without a last beat")
  `ASSERT_CLK(a_stall_only_on_last,
    !data_ready |-> beat_valid && beat_last && result_valid && !result_ready,
    "input stalled without a blocked verdict")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for strict_utf8_validator: byte strings in, one verdict per string out.
// Depends on u8v_pkg and the validator RTL; carries its own decoder to predict each verdict.

module tb;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RAND_BEATS  = 1000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [7:0] b;
    logic       lst;
    logic       drain;   // wait for all verdicts before offering this beat
  } beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       data_valid = 1'b0;
  logic       data_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic       string_valid;

  strict_utf8_validator dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .string_valid (string_valid)
  );

  always #10 clk = ~clk;

  beat_t       stim_q[$];
  logic [7:0]  str_q[$];
  logic        verdict_q[$];

  // decoder state of the predictor
  logic [1:0]  pend;
  logic [1:0]  seq_len;
  logic [20:0] scalar;
  logic        broken;

  logic        fired = 1'b0;
  int unsigned beats_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned valid_seen = 0;
  int unsigned verdict_errors = 0;
  int unsigned stall_cycles = 0;
  logic [9:0]  hold_left = '0;
  logic        hold_used = 1'b0;

  function automatic logic scalar_legal(input logic [20:0] v, input logic [1:0] n);
    logic [20:0] floor_v;
    case (n)
      u8v_pkg::EXTRA_ONE:   floor_v = 21'h00080;
      u8v_pkg::EXTRA_TWO:   floor_v = 21'h00800;
      u8v_pkg::EXTRA_THREE: floor_v = 21'h10000;
      default:              floor_v = 21'h00000;
    endcase
    return v >= floor_v && v <= 21'h10FFFF && !(v >= 21'h0D800 && v <= 21'h0DFFF)
           && v >= 21'h00020 && v != 21'h0007F;
  endfunction

  task automatic decode_beat(input logic [7:0] b, input logic lst);
    if (!broken) begin
      if (pend == u8v_pkg::EXTRA_NONE) begin
        if (!b[7]) begin
          if (!scalar_legal({14'd0, b[6:0]}, u8v_pkg::EXTRA_NONE)) broken = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          scalar = {16'd0, b[4:0]}; seq_len = u8v_pkg::EXTRA_ONE; pend = u8v_pkg::EXTRA_ONE;
        end else if (b[7:4] == 4'b1110) begin
          scalar = {17'd0, b[3:0]}; seq_len = u8v_pkg::EXTRA_TWO; pend = u8v_pkg::EXTRA_TWO;
        end else if (b[7:3] == 5'b11110) begin
          scalar = {18'd0, b[2:0]};
          seq_len = u8v_pkg::EXTRA_THREE;
          pend = u8v_pkg::EXTRA_THREE;
        end else begin
          broken = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        broken = 1'b1;
      end else begin
        scalar = {scalar[14:0], b[5:0]};
        pend = pend - 2'd1;
        if (pend == u8v_pkg::EXTRA_NONE) begin
          if (!scalar_legal(scalar, seq_len)) broken = 1'b1;
          seq_len = u8v_pkg::EXTRA_NONE;
          scalar = '0;
        end
      end
    end
    if (lst) begin
      verdict_q.push_back(!broken && pend == u8v_pkg::EXTRA_NONE);
      pend = u8v_pkg::EXTRA_NONE; seq_len = u8v_pkg::EXTRA_NONE; scalar = '0; broken = 1'b0;
    end
  endtask

  // Moves the string under construction onto the beat queue, marking its final byte.
  task automatic flush_string(input logic drain);
    beat_t nb;
    for (int i = 0; i < str_q.size(); i++) begin
      nb.b = str_q[i];
      nb.lst = (i == str_q.size() - 1);
      nb.drain = drain && (i == 0);
      stim_q.push_back(nb);
    end
    str_q.delete();
  endtask

  // One code point, mostly well formed; about a third carry some fault.
  task automatic add_scalar();
    int unsigned kind;
    int unsigned len;
    int unsigned keep;
    logic [20:0] v;
    logic [7:0]  enc [4];
    kind = $urandom_range(99);
    len = $urandom_range(4, 1);
    case (len)
      1: v = 21'($urandom_range(21'h7E, 21'h20));
      2: v = 21'($urandom_range(21'h7FF, 21'h80));
      3: begin
        v = 21'($urandom_range(21'hFFFF, 21'h800));
        if (v >= 21'hD800 && v <= 21'hDFFF) v = v ^ 21'h8000;
      end
      default: v = 21'($urandom_range(21'h10FFFF, 21'h10000));
    endcase
    keep = len;
    if (kind >= 67) begin
      case ($urandom_range(5))
        0: v = $urandom_range(1) ? 21'h7F : 21'($urandom_range(31));
        1: begin
          len = $urandom_range(4, 2);
          v = (len == 2) ? 21'($urandom_range(21'h7F)) :
              (len == 3) ? 21'($urandom_range(21'h7FF)) :
                           21'($urandom_range(21'hFFFF));
          keep = len;
        end
        2: begin len = 3; keep = 3; v = 21'($urandom_range(21'hDFFF, 21'hD800)); end
        3: begin len = 4; keep = 4; v = 21'($urandom_range(21'h1FFFFF, 21'h110000)); end
        4: begin
          if (len == 1) len = 2;
          keep = $urandom_range(len - 1, 1);
        end
        default: begin
          str_q.push_back($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                            : 8'($urandom_range(8'hFF, 8'hF8)));
          keep = 0;
        end
      endcase
    end
    case (len)
      1: enc[0] = {1'b0, v[6:0]};
      2: begin enc[0] = {3'b110, v[10:6]}; enc[1] = {2'b10, v[5:0]}; end
      3: begin
        enc[0] = {4'b1110, v[15:12]}; enc[1] = {2'b10, v[11:6]}; enc[2] = {2'b10, v[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, v[20:18]}; enc[1] = {2'b10, v[17:12]};
        enc[2] = {2'b10, v[11:6]};     enc[3] = {2'b10, v[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) str_q.push_back(enc[i]);
  endtask

  // Sender: new beat only once the current one has been taken
  always @(negedge clk) begin
    beat_t nb;
    logic  quiet;
    quiet = beats_taken >= 400 && beats_taken < 650;
    if (rst) begin
      data_valid <= 1'b0;
      data_byte <= 8'h00;
      last_byte <= 1'b0;
    end else if (!data_valid || fired) begin
      if (stim_q.size() != 0 && !(stim_q[0].drain && verdict_q.size() != 0)
          && (quiet || $urandom_range(99) >= 12)) begin
        nb = stim_q.pop_front();
        data_valid <= 1'b1;
        data_byte <= nb.b;
        last_byte <= nb.lst;
      end else begin
        data_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the block backs up
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (!hold_used && verdicts_seen >= 30) begin
      hold_used <= 1'b1;
      hold_left <= 10'(HOLD_CYCLES);
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 10'd1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= (verdicts_seen >= 50 && verdicts_seen < 75) || $urandom_range(99) >= 12;
    end
  end

  // Monitor: check verdict beats, then predict from the byte beat taken at this edge
  always @(posedge clk) begin
    logic want;
    if (rst) begin
      fired <= 1'b0;
      pend = u8v_pkg::EXTRA_NONE; seq_len = u8v_pkg::EXTRA_NONE; scalar = '0; broken = 1'b0;
    end else begin
      fired <= data_valid && data_ready;
      if (result_valid && result_ready) begin
        verdicts_seen++;
        if (string_valid) valid_seen++;
        if (verdict_q.size() == 0) begin
          verdict_errors++;
          if (verdict_errors <= MAX_REPORTS)
            $display("%0t: verdict %b with no string pending", $realtime, string_valid);
        end else begin
          want = verdict_q.pop_front();
          if (string_valid !== want) begin
            verdict_errors++;
            if (verdict_errors <= MAX_REPORTS)
              $display("%0t: verdict %0d: expected %b, got %b", $realtime,
                       verdicts_seen, want, string_valid);
          end
        end
      end
      if (data_valid && data_ready) begin
        beats_taken++;
        decode_beat(data_byte, last_byte);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d verdicts still due", stall_cycles,
               verdict_q.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned rand_beats;
    int unsigned n;
    logic        drain_mid;
    rand_beats = 0;
    drain_mid = 1'b0;

    // directed strings
    str_q = '{8'h41};                      flush_string(1'b0);
    str_q = '{8'h00};                      flush_string(1'b0);  // zero byte
    str_q = '{8'h7F};                      flush_string(1'b0);
    str_q = '{8'hC3, 8'hA9};               flush_string(1'b0);
    str_q = '{8'hC0, 8'h80};               flush_string(1'b0);  // overlong
    str_q = '{8'hE2, 8'h82};               flush_string(1'b0);  // ends mid-sequence
    str_q = '{8'hED, 8'hA0, 8'h80};        flush_string(1'b0);  // surrogate
    str_q = '{8'hF0, 8'h9F, 8'h98, 8'h80}; flush_string(1'b0);
    str_q = '{8'hF5, 8'h80, 8'h80, 8'h80}; flush_string(1'b0);  // lead past U+10FFFF
    str_q = '{8'hFF};                      flush_string(1'b0);
    str_q = '{8'h80};                      flush_string(1'b0);  // stray continuation
    str_q = '{8'hC3, 8'h41};               flush_string(1'b0);  // missing continuation

    while (rand_beats < RAND_BEATS) begin
      n = $urandom_range(6, 1);
      if ($urandom_range(99) < 15) begin
        repeat (n) str_q.push_back(8'($urandom_range(255)));
      end else begin
        repeat (n) add_scalar();
      end
      if (str_q.size() == 0) str_q.push_back(8'($urandom_range(255)));
      rand_beats += str_q.size();
      flush_string(rand_beats == str_q.size() || (rand_beats >= 500 && !drain_mid));
      if (rand_beats >= 500) drain_mid = 1'b1;
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (stim_q.size() == 0);
    while (data_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d bytes in %0d strings checked, %0d judged valid; one long output hold-off",
             beats_taken, verdicts_seen, valid_seen);
    $display("and a sender pause to drain were included, %0d verdict errors", verdict_errors);
    if (verdict_errors == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/u8v_pkg.sv
sv/u8v_in_stage.sv
sv/u8v_step.sv
sv/strict_utf8_validator.sv
verif/tb.sv
